[rtl/core/cpof_pkg.sv]
// Package for the command packet FIFO: entry type, codes and packet unpacking.
`timescale 1ns / 1ps

package cpof_pkg;

    // Default ring depth
    localparam int CPOF_DEPTH = 16;

    // Width of the reported fill count
    localparam int FILL_W = 5;

    // Operation codes on the cmd input
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // One stored entry, unpacked from an 11-byte packet
    typedef struct packed {
        logic [7:0]         seq;
        logic [2:0]         sensor;
        logic [4:0]         command;
        logic [7:0]         inst_num;
        logic signed [15:0] value_one;
        logic signed [15:0] value_two;
        logic signed [15:0] value_three;
        logic signed [15:0] value_four;
    } entry_t;

    // Split the kind byte and join little-endian value bytes
    function automatic entry_t unpack_packet(
        input logic [7:0] seq_byte,
        input logic [7:0] kind_byte,
        input logic [7:0] instance_byte,
        input logic [7:0] first_low,
        input logic [7:0] first_high,
        input logic [7:0] second_low,
        input logic [7:0] second_high,
        input logic [7:0] third_low,
        input logic [7:0] third_high,
        input logic [7:0] fourth_low,
        input logic [7:0] fourth_high
    );
        entry_t e;
        e.seq         = seq_byte;
        e.sensor      = kind_byte[7:5];
        e.command     = kind_byte[4:0];
        e.inst_num    = instance_byte;
        e.value_one   = signed'({first_high, first_low});
        e.value_two   = signed'({second_high, second_low});
        e.value_three = signed'({third_high, third_low});
        e.value_four  = signed'({fourth_high, fourth_low});
        return e;
    endfunction

endpackage

[rtl/core/command_packet_overwrite_fifo.sv]
// Top level of the overwriting command packet FIFO.
// A result is registered: it becomes valid in the cycle after its item is accepted.
// Throughput: one push or pop per cycle while the consumer keeps out_ready high; the output
// register lets a new item in while the previous result is taken in the same cycle.
// Reset clears the ring pointers, the fill count and the output valid; the entry
// storage is not cleared, since a slot is only read after it has been written.
`timescale 1ns / 1ps

module command_packet_overwrite_fifo
    import cpof_pkg::*;
#(
    parameter int DEPTH = CPOF_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic [7:0]         seq_byte,
    input  logic [7:0]         kind_byte,
    input  logic [7:0]         instance_byte,
    input  logic [7:0]         first_low,
    input  logic [7:0]         first_high,
    input  logic [7:0]         second_low,
    input  logic [7:0]         second_high,
    input  logic [7:0]         third_low,
    input  logic [7:0]         third_high,
    input  logic [7:0]         fourth_low,
    input  logic [7:0]         fourth_high,

    output logic               out_valid,
    input  logic               out_ready,
    output logic               pop_ok,
    output logic               overwrote,
    output logic [7:0]         seq_out,
    output logic [2:0]         sensor_type,
    output logic [4:0]         command_code,
    output logic [7:0]         instance_out,
    output logic signed [15:0] value_one,
    output logic signed [15:0] value_two,
    output logic signed [15:0] value_three,
    output logic signed [15:0] value_four,
    output logic [4:0]         fill_count
);

    // Slot index and count widths follow the ring depth
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    // Ring control state
    logic [AW-1:0]     wr_idx_reg, wr_idx_next;
    logic [AW-1:0]     rd_idx_reg, rd_idx_next;
    logic [CW-1:0]     count_reg, count_next;

    // Result register; the popped entry sits in the storage read register
    logic              out_valid_reg;
    logic              pop_ok_reg;
    logic              overwrote_reg;
    logic [FILL_W-1:0] fill_reg;

    logic              accept;
    logic              is_pop;
    logic              full;
    logic              empty;
    logic              wr_en;
    logic              rd_en;
    entry_t            wr_entry;
    entry_t            rd_entry;

    // Advance a slot index around the ring
    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx);
        return (idx == LAST_SLOT) ? '0 : idx + AW'(1);
    endfunction

    // Take a new item whenever the result register is empty or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign is_pop = (cmd == CMD_POP);
    assign full   = (count_reg == FULL_COUNT);
    assign empty  = (count_reg == '0);

    // A push always writes; a pop on an empty ring does nothing
    assign wr_en = accept && !is_pop;
    assign rd_en = accept && is_pop && !empty;

    assign wr_entry = unpack_packet(seq_byte, kind_byte, instance_byte,
                                    first_low, first_high, second_low, second_high,
                                    third_low, third_high, fourth_low, fourth_high);

    always_comb
    begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_idx_next = next_slot(wr_idx_reg);
            if (full)
            begin
                // Drop the oldest entry: the new one takes its slot
                rd_idx_next = next_slot(rd_idx_reg);
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
        else if (rd_en)
        begin
            rd_idx_next = next_slot(rd_idx_reg);
            count_next  = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            count_reg  <= count_next;
        end
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pop_ok_reg    <= rd_en;
            overwrote_reg <= wr_en && full;
            // Report the count masked to the port width
            fill_reg      <= FILL_W'(count_next);
        end
    end

    cpof_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx_reg),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_entry)
    );

    // Zero the data fields of any result that is not a successful pop
    assign out_valid    = out_valid_reg;
    assign pop_ok       = pop_ok_reg;
    assign overwrote    = overwrote_reg;
    assign fill_count   = fill_reg;
    assign seq_out      = pop_ok_reg ? rd_entry.seq         : '0;
    assign sensor_type  = pop_ok_reg ? rd_entry.sensor      : '0;
    assign command_code = pop_ok_reg ? rd_entry.command     : '0;
    assign instance_out = pop_ok_reg ? rd_entry.inst_num    : '0;
    assign value_one    = pop_ok_reg ? rd_entry.value_one   : '0;
    assign value_two    = pop_ok_reg ? rd_entry.value_two   : '0;
    assign value_three  = pop_ok_reg ? rd_entry.value_three : '0;
    assign value_four   = pop_ok_reg ? rd_entry.value_four  : '0;

`ifndef SYNTHESIS
    // The count never goes past the ring depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("fill count exceeds depth");

    // A result is never both a successful pop and an overwrite
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(pop_ok_reg && overwrote_reg))
        else $error("pop_ok and overwrote both set");

    // A push into a full ring keeps it full and reports the drop
    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_pop && full) |=> (count_reg == FULL_COUNT) && overwrote_reg)
        else $error("full push did not overwrite");

    // A pop on an empty ring leaves the ring alone and fails
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_pop && empty) |=> !pop_ok_reg && (count_reg == '0)
            && $stable(rd_idx_reg) && $stable(wr_idx_reg))
        else $error("pop on empty ring changed state");
`endif

endmodule

[rtl/core/cpof_store.sv]
// Entry storage for the command packet FIFO: one write port, one registered read port.
`timescale 1ns / 1ps

module cpof_store
    import cpof_pkg::*;
#(
    parameter int DEPTH = CPOF_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[tb/testbench.sv]
// Self-checking testbench for the overwriting command packet FIFO.
`timescale 1ns / 1ps

module testbench;
    import cpof_pkg::*;

    // Random part length, and how many of its last items run without idling
    localparam int RANDOM_ITEMS  = 1100;
    localparam int STEADY_ITEMS  = 150;
    // Cycles with no handshake on either side before the run is declared hung
    localparam int HANG_LIMIT    = 500;
    // Results are registered; extra cycles to wait for strays before the verdict
    localparam int DRAIN_CYCLES  = 4;

    // One result as the block presents it
    typedef struct packed {
        logic        pop_ok;
        logic        overwrote;
        logic [7:0]  seq;
        logic [2:0]  sensor;
        logic [4:0]  command;
        logic [7:0]  inst_id;
        logic [15:0] val_one;
        logic [15:0] val_two;
        logic [15:0] val_three;
        logic [15:0] val_four;
        logic [4:0]  fill;
    } fifo_result_t;

    // Ring predictor plus the queue of results still owed by the block.
    // Packets are held raw: byte k sits in bits 8k+7..8k.
    class ring_scoreboard;
        logic [87:0]  slots [CPOF_DEPTH];
        int           wr_ptr;
        int           rd_ptr;
        int           held;
        int           failures;
        fifo_result_t owed_results [$];

        function new();
            wr_ptr   = 0;
            rd_ptr   = 0;
            held     = 0;
            failures = 0;
        endfunction

        // Advance the ring for one accepted item and queue what it must produce
        function void note_item(logic op, logic [87:0] pkt);
            fifo_result_t res;
            logic [87:0]  s;
            res = '0;
            if (op == CMD_PUSH)
            begin
                slots[wr_ptr] = pkt;
                wr_ptr = (wr_ptr + 1) % CPOF_DEPTH;
                if (held < CPOF_DEPTH)
                    held++;
                else
                begin
                    // full: drop the oldest entry
                    rd_ptr = (rd_ptr + 1) % CPOF_DEPTH;
                    res.overwrote = 1'b1;
                end
            end
            else if (held > 0)
            begin
                s = slots[rd_ptr];
                res.pop_ok    = 1'b1;
                res.seq       = s[7:0];
                res.sensor    = s[15:13];
                res.command   = s[12:8];
                res.inst_id   = s[23:16];
                res.val_one   = s[39:24];
                res.val_two   = s[55:40];
                res.val_three = s[71:56];
                res.val_four  = s[87:72];
                rd_ptr = (rd_ptr + 1) % CPOF_DEPTH;
                held--;
            end
            res.fill = held[4:0];
            owed_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
                failures++;
            end
        endfunction

        // Match one result taken from the block against the oldest one owed
        function void check_result(fifo_result_t got);
            fifo_result_t want;
            if (owed_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual %0h", $time, got);
                failures++;
                return;
            end
            want = owed_results.pop_front();
            compare_field("pop_ok",       want.pop_ok,    got.pop_ok);
            compare_field("overwrote",    want.overwrote, got.overwrote);
            compare_field("seq_out",      want.seq,       got.seq);
            compare_field("sensor_type",  want.sensor,    got.sensor);
            compare_field("command_code", want.command,   got.command);
            compare_field("instance_out", want.inst_id,   got.inst_id);
            compare_field("value_one",    want.val_one,   got.val_one);
            compare_field("value_two",    want.val_two,   got.val_two);
            compare_field("value_three",  want.val_three, got.val_three);
            compare_field("value_four",   want.val_four,  got.val_four);
            compare_field("fill_count",   want.fill,      got.fill);
        endfunction

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               cmd;
    logic [7:0]         seq_byte;
    logic [7:0]         kind_byte;
    logic [7:0]         instance_byte;
    logic [7:0]         first_low;
    logic [7:0]         first_high;
    logic [7:0]         second_low;
    logic [7:0]         second_high;
    logic [7:0]         third_low;
    logic [7:0]         third_high;
    logic [7:0]         fourth_low;
    logic [7:0]         fourth_high;
    logic               out_valid;
    logic               out_ready;
    logic               pop_ok;
    logic               overwrote;
    logic [7:0]         seq_out;
    logic [2:0]         sensor_type;
    logic [4:0]         command_code;
    logic [7:0]         instance_out;
    logic signed [15:0] value_one;
    logic signed [15:0] value_two;
    logic signed [15:0] value_three;
    logic signed [15:0] value_four;
    logic [4:0]         fill_count;

    ring_scoreboard board;
    // Random idling on both sides is allowed while this is set
    bit             idling_on;
    int             stall_left;
    int             quiet_cycles;

    command_packet_overwrite_fifo uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .seq_byte      (seq_byte),
        .kind_byte     (kind_byte),
        .instance_byte (instance_byte),
        .first_low     (first_low),
        .first_high    (first_high),
        .second_low    (second_low),
        .second_high   (second_high),
        .third_low     (third_low),
        .third_high    (third_high),
        .fourth_low    (fourth_low),
        .fourth_high   (fourth_high),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pop_ok        (pop_ok),
        .overwrote     (overwrote),
        .seq_out       (seq_out),
        .sensor_type   (sensor_type),
        .command_code  (command_code),
        .instance_out  (instance_out),
        .value_one     (value_one),
        .value_two     (value_two),
        .value_three   (value_three),
        .value_four    (value_four),
        .fill_count    (fill_count)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Build an 11-byte packet; the four values go out low byte first
    function automatic logic [87:0] make_packet(
        logic [7:0] seq, logic [7:0] kind, logic [7:0] inst,
        logic [15:0] v1, logic [15:0] v2, logic [15:0] v3, logic [15:0] v4);
        return {v4, v3, v2, v1, inst, kind, seq};
    endfunction

    // Random 16-bit value, leaning toward the signed extremes now and then
    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    function automatic logic [87:0] random_packet();
        return make_packet(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), pick_value(), pick_value(),
                           pick_value(), pick_value());
    endfunction

    // Present one item, hold it until the block takes it, then note it.
    // Called at a rising edge; returns at the edge where the item is accepted.
    task automatic send_item(input logic op, input logic [87:0] pkt);
        int gap;
        if (idling_on && $urandom_range(0, 7) == 0)
        begin
            // idle the input for a burst of cycles
            gap = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        cmd           <= op;
        seq_byte      <= pkt[7:0];
        kind_byte     <= pkt[15:8];
        instance_byte <= pkt[23:16];
        first_low     <= pkt[31:24];
        first_high    <= pkt[39:32];
        second_low    <= pkt[47:40];
        second_high   <= pkt[55:48];
        third_low     <= pkt[63:56];
        third_high    <= pkt[71:64];
        fourth_low    <= pkt[79:72];
        fourth_high   <= pkt[87:80];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_item(op, pkt);
    endtask

    // Output side: take results, check them, and stall ready in random bursts
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            board.check_result({pop_ok, overwrote, seq_out, sensor_type, command_code,
                                instance_out, value_one, value_two, value_three,
                                value_four, fill_count});
        if (stall_left > 0)
        begin
            stall_left--;
            if (stall_left == 0)
                out_ready <= 1'b1;
        end
        else if (idling_on && $urandom_range(0, 11) == 0)
        begin
            stall_left = $urandom_range(1, 17);
            out_ready <= 1'b0;
        end
    end

    // Watchdog: end the run if neither side moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int          made;
        int          phase_len;
        int          push_pct;
        logic        op;
        board        = new();
        idling_on    = 1'b1;
        stall_left   = 0;
        quiet_cycles = 0;

        // Drive every input to a known value and hold reset low
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        out_ready     <= 1'b1;
        cmd           <= CMD_PUSH;
        seq_byte      <= '0;
        kind_byte     <= '0;
        instance_byte <= '0;
        first_low     <= '0;
        first_high    <= '0;
        second_low    <= '0;
        second_high   <= '0;
        third_low     <= '0;
        third_high    <= '0;
        fourth_low    <= '0;
        fourth_high   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: pop on an empty ring first
        send_item(CMD_POP, random_packet());
        // All-zero and all-ones packets, then the signed boundaries
        send_item(CMD_PUSH, make_packet(8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000,
                                        16'h0000, 16'h0000));
        send_item(CMD_PUSH, make_packet(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                                        16'hFFFF, 16'hFFFF));
        send_item(CMD_PUSH, make_packet(8'h80, 8'hAA, 8'h5A, 16'h8000, 16'h7FFF,
                                        16'h0001, 16'hFFFE));
        // Drain all three, then pop empty again
        repeat (4) send_item(CMD_POP, random_packet());
        // Fill to full; the seventeenth push drops the oldest entry
        for (int i = 0; i < CPOF_DEPTH + 1; i++)
            send_item(CMD_PUSH, make_packet(8'(i), 8'(i * 37), 8'(255 - i),
                                            16'(i * 4099), 16'(-i), 16'(i << 11),
                                            16'(i * 771)));

        // Random part: phases with different push/pop balance, so the ring
        // swings between empty and full and overwrites often
        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            phase_len = $urandom_range(20, 80);
            case ($urandom_range(0, 3))
                0:       push_pct = 15;
                1:       push_pct = 50;
                2:       push_pct = 80;
                default: push_pct = 95;
            endcase
            for (int k = 0; k < phase_len && made < RANDOM_ITEMS; k++)
            begin
                // last stretch runs with no idling on either side
                if (made >= RANDOM_ITEMS - STEADY_ITEMS)
                    idling_on = 1'b0;
                op = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
                send_item(op, random_packet());
                made++;
            end
        end
        in_valid <= 1'b0;

        // Wait for every owed result, then a few more cycles for strays
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[command_packet_overwrite_fifo.f]
rtl/core/cpof_pkg.sv
rtl/core/cpof_store.sv
rtl/core/command_packet_overwrite_fifo.sv
tb/testbench.sv
